// ===== design/vlmf_pkg.sv =====
// Shared types and constants of the variable-length message FIFO.
// No dependencies; the top level, controller and datapath import this package.
`timescale 1ns / 1ps
package vlmf_pkg;

  localparam int unsigned DefBufferBytes = 16384;
  localparam int unsigned DefQueueSlots  = 256;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;

  localparam logic [2:0] StPushed    = 3'd0;
  localparam logic [2:0] StOverwrite = 3'd1;
  localparam logic [2:0] StDropByte  = 3'd2;
  localparam logic [2:0] StByteOut   = 3'd3;
  localparam logic [2:0] StEmpty     = 3'd4;
  localparam logic [2:0] StTooLong   = 3'd5;

  localparam logic RegCheckEnable = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_LOAD = 4'b1000
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic fetch;
    logic load;
  } ctrl_cmd_t;

endpackage

// ===== design/vlmf_if.sv =====
// Handshake channels of the message FIFO: the input beat and the result beat.
// No dependencies.
`timescale 1ns / 1ps
interface vlmf_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic        end_of_message;
  logic [31:0] tag;
  logic [14:0] max_len;
  modport source (output valid, cmd, data_byte, end_of_message, tag, max_len, input ready);
  modport sink (input valid, cmd, data_byte, end_of_message, tag, max_len, output ready);
endinterface

interface vlmf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [31:0] out_tag;
  logic [14:0] dropped_length;
  logic [14:0] head_length;
  logic [8:0]  message_count;
  modport source (output valid, status, out_byte, out_last, out_tag, dropped_length,
                  head_length, message_count, input ready);
  modport sink (input valid, status, out_byte, out_last, out_tag, dropped_length,
                head_length, message_count, output ready);
endinterface

// ===== design/variable_length_message_fifo.sv =====
// Top level of the variable-length message FIFO: configuration port,
// controller and datapath. Uses vlmf_pkg, vlmf_if, vlmf_ctrl, vlmf_datapath.
`timescale 1ns / 1ps
// Every beat, push or pop, passes through execute with the byte-ring access,
// descriptor fetch of the new head slot, and result load before its result
// is presented. The next beat is taken once the previous result is handed
// over, at the earliest in the same cycle, so a held result stalls the
// input. There is no clearing pass after reset: slot occupancy lives in
// flip-flops that reset clears at once.
module variable_length_message_fifo #(
  parameter int unsigned BUFFER_BYTES = vlmf_pkg::DefBufferBytes,
  parameter int unsigned SLOT_COUNT   = vlmf_pkg::DefQueueSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vlmf_in_if.sink     in_s,
  vlmf_out_if.source  out_s,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vlmf_pkg::*;

  ctrl_cmd_t  cmd;
  logic       check_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegCheckEnable) ? {31'd0, check_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegCheckEnable) begin
      check_q <= pwdata[0];
    end
  end

  vlmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .out_ready_i (out_s.ready),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_s.valid),
    .cmd_o       (cmd)
  );

  vlmf_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .SLOT_COUNT   (SLOT_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .check_enable_i   (check_q),
    .cmd_in_i         (in_s.cmd),
    .data_byte_i      (in_s.data_byte),
    .eom_i            (in_s.end_of_message),
    .tag_i            (in_s.tag),
    .max_len_i        (in_s.max_len),
    .status_out_o     (out_s.status),
    .out_byte_o       (out_s.out_byte),
    .out_last_o       (out_s.out_last),
    .out_tag_o        (out_s.out_tag),
    .dropped_length_o (out_s.dropped_length),
    .head_length_o    (out_s.head_length),
    .message_count_o  (out_s.message_count)
  );

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_s.valid && in_s.ready |=> !in_s.ready)
    else $error("beat accepted while the previous one is still executing");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid |-> out_s.message_count <= 9'd256)
    else $error("message count above its saturation level");

  a_last_only_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && out_s.status != StByteOut |-> !out_s.out_last && out_s.out_byte == 8'd0)
    else $error("byte fields set on a result that carries no byte");

  a_load_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> out_s.valid)
    else $error("result load did not raise the output valid");
endmodule

// ===== design/vlmf_ctrl.sv =====
// Controller of the message FIFO: sequences each beat through execute,
// descriptor fetch and result load, and owns the handshakes. Uses vlmf_pkg.
`timescale 1ns / 1ps
module vlmf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output vlmf_pkg::ctrl_cmd_t  cmd_o
);
  import vlmf_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  assign in_ready_o    = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o   = out_valid_q;

  always_comb begin
    cmd_o.accept = in_valid_i && in_ready_o;
    cmd_o.exec   = (state_q == ST_EXEC);
    cmd_o.fetch  = (state_q == ST_WAIT);
    cmd_o.load   = (state_q == ST_LOAD);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_WAIT;
      ST_WAIT: state_d = ST_LOAD;
      ST_LOAD: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// ===== design/vlmf_datapath.sv =====
// Datapath of the message FIFO: byte ring, descriptor ring, pointers, head
// cache and result register. Driven by vlmf_ctrl commands; uses vlmf_pkg.
`timescale 1ns / 1ps
module vlmf_datapath #(
  parameter int unsigned BUFFER_BYTES = vlmf_pkg::DefBufferBytes,
  parameter int unsigned SLOT_COUNT   = vlmf_pkg::DefQueueSlots
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vlmf_pkg::ctrl_cmd_t  cmd_i,
  input  logic                 check_enable_i,
  input  logic                 cmd_in_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 eom_i,
  input  logic [31:0]          tag_i,
  input  logic [14:0]          max_len_i,
  output logic [2:0]           status_out_o,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic [31:0]          out_tag_o,
  output logic [14:0]          dropped_length_o,
  output logic [14:0]          head_length_o,
  output logic [8:0]           message_count_o
);
  import vlmf_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned QW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned LW = (CW > 15) ? CW : 15;
  localparam int unsigned MW = (QW > 9) ? QW : 9;
  localparam logic [CW:0]   BufLen   = (CW + 1)'(BUFFER_BYTES);
  localparam logic [AW-1:0] LastAddr = AW'(BUFFER_BYTES - 1);
  localparam logic [SW-1:0] LastSlot = SW'(SLOT_COUNT - 1);
  localparam logic [MW-1:0] CountCap = MW'(256);

  logic [7:0]    ring_q [BUFFER_BYTES];
  logic [AW-1:0] slot_start_q [SLOT_COUNT];
  logic [CW-1:0] slot_len_q [SLOT_COUNT];
  logic [31:0]   slot_tag_q [SLOT_COUNT];

  logic          cmd_q, eom_q;
  logic [7:0]    byte_q;
  logic [31:0]   tag_q;
  logic [14:0]   max_len_q;

  logic [AW-1:0] wr_addr_q, wr_addr_d, cur_start_q, cur_start_d;
  logic [CW-1:0] cur_cnt_q, cur_cnt_d, offset_q, offset_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [SW-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [QW-1:0] queued_q, queued_d;

  logic [AW-1:0] hd_start_q;
  logic [CW-1:0] hd_len_q;
  logic [31:0]   hd_tag_q;

  logic [7:0]    ring_rd_q;
  logic [AW-1:0] srd_start_q;
  logic [CW-1:0] srd_len_q;
  logic [31:0]   srd_tag_q;

  logic [2:0]    res_status_q, res_status_d;
  logic          res_last_q, res_last_d, res_byte_q, res_byte_d;
  logic [31:0]   res_tag_q, res_tag_d;
  logic [CW-1:0] res_dlen_q, res_dlen_d;

  logic          ring_we, slot_we, full, do_free;
  logic [AW-1:0] rd_addr;
  logic [CW:0]   addr_sum;
  logic [CW-1:0] off_next;
  logic [LW-1:0] len_ext, max_ext, dlen_ext, head_ext;
  logic [MW-1:0] queued_ext;

  assign full     = ({1'b0, cur_cnt_q} >= BufLen);
  assign addr_sum = (CW + 1)'(hd_start_q) + (CW + 1)'(offset_q);
  assign rd_addr  = (addr_sum >= BufLen) ? AW'(addr_sum - BufLen) : AW'(addr_sum);
  assign off_next = offset_q + CW'(1);
  assign len_ext  = LW'(hd_len_q);
  assign max_ext  = LW'(max_len_q);

  always_comb begin
    wr_addr_d    = wr_addr_q;
    cur_start_d  = cur_start_q;
    cur_cnt_d    = cur_cnt_q;
    offset_d     = offset_q;
    valid_d      = valid_q;
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    queued_d     = queued_q;
    res_status_d = StPushed;
    res_last_d   = 1'b0;
    res_byte_d   = 1'b0;
    res_tag_d    = '0;
    res_dlen_d   = '0;
    ring_we      = 1'b0;
    slot_we      = 1'b0;
    do_free      = 1'b0;
    if (cmd_q == CmdPush) begin
      if (full) begin
        res_status_d = StDropByte;
      end else begin
        ring_we   = 1'b1;
        wr_addr_d = (wr_addr_q == LastAddr) ? '0 : wr_addr_q + AW'(1);
        cur_cnt_d = cur_cnt_q + CW'(1);
      end
      if (eom_q) begin
        if (valid_q[wr_idx_q]) begin
          if (!full && check_enable_i) begin
            res_status_d = StOverwrite;
          end
          do_free = 1'b1;
        end
        slot_we = 1'b1;
      end
    end else begin
      if (!valid_q[rd_idx_q]) begin
        res_status_d = StEmpty;
      end else if (offset_q == '0 && len_ext > max_ext) begin
        res_status_d = StTooLong;
        res_dlen_d   = hd_len_q;
        do_free      = 1'b1;
      end else begin
        res_status_d = StByteOut;
        res_byte_d   = 1'b1;
        res_tag_d    = hd_tag_q;
        offset_d     = off_next;
        if (off_next >= hd_len_q) begin
          res_last_d = 1'b1;
          do_free    = 1'b1;
        end
      end
    end
    if (do_free) begin
      valid_d[rd_idx_q] = 1'b0;
      rd_idx_d = (rd_idx_q == LastSlot) ? '0 : rd_idx_q + SW'(1);
      offset_d = '0;
      if (queued_q != '0) begin
        queued_d = queued_q - QW'(1);
      end
    end
    if (slot_we) begin
      valid_d[wr_idx_q] = 1'b1;
      wr_idx_d    = (wr_idx_q == LastSlot) ? '0 : wr_idx_q + SW'(1);
      queued_d    = queued_d + QW'(1);
      cur_start_d = wr_addr_d;
      cur_cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && ring_we) begin
      ring_q[wr_addr_q] <= byte_q;
    end
    if (cmd_i.exec) begin
      ring_rd_q <= ring_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && slot_we) begin
      slot_start_q[wr_idx_q] <= cur_start_q;
      slot_len_q[wr_idx_q]   <= cur_cnt_d == '0 ? (full ? cur_cnt_q : cur_cnt_q + CW'(1))
                                                : cur_cnt_d;
      slot_tag_q[wr_idx_q]   <= tag_q;
    end
    if (cmd_i.fetch) begin
      srd_start_q <= slot_start_q[rd_idx_q];
      srd_len_q   <= slot_len_q[rd_idx_q];
      srd_tag_q   <= slot_tag_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_addr_q   <= '0;
      cur_start_q <= '0;
      cur_cnt_q   <= '0;
      offset_q    <= '0;
      valid_q     <= '0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      queued_q    <= '0;
    end else if (cmd_i.exec) begin
      wr_addr_q   <= wr_addr_d;
      cur_start_q <= cur_start_d;
      cur_cnt_q   <= cur_cnt_d;
      offset_q    <= offset_d;
      valid_q     <= valid_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      queued_q    <= queued_d;
    end
  end

  assign head_ext   = LW'(srd_len_q);
  assign dlen_ext   = LW'(res_dlen_q);
  assign queued_ext = MW'(queued_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q     <= cmd_in_i;
      byte_q    <= data_byte_i;
      eom_q     <= eom_i;
      tag_q     <= tag_i;
      max_len_q <= max_len_i;
    end
    if (cmd_i.exec) begin
      res_status_q <= res_status_d;
      res_last_q   <= res_last_d;
      res_byte_q   <= res_byte_d;
      res_tag_q    <= res_tag_d;
      res_dlen_q   <= res_dlen_d;
    end
    if (cmd_i.load) begin
      hd_start_q       <= srd_start_q;
      hd_len_q         <= srd_len_q;
      hd_tag_q         <= srd_tag_q;
      status_out_o     <= res_status_q;
      out_byte_o       <= res_byte_q ? ring_rd_q : 8'd0;
      out_last_o       <= res_last_q;
      out_tag_o        <= res_tag_q;
      dropped_length_o <= dlen_ext[14:0];
      head_length_o    <= valid_q[rd_idx_q] ? head_ext[14:0] : 15'd0;
      message_count_o  <= (queued_ext > CountCap) ? 9'd256 : queued_ext[8:0];
    end
  end
endmodule
